### rtl/wrrm_pkg.sv
package wrrm_pkg;

    localparam int FIELD_W = 16;
    localparam int OPCODE_W = 2;
    localparam logic [FIELD_W-1:0] RING_SIZE_RESET = 16'hFFFF;

    typedef enum logic [OPCODE_W-1:0] {
        OP_RESERVE     = 2'd0,
        OP_COMMIT      = 2'd1,
        OP_RELEASE     = 2'd2,
        OP_FAST_COMMIT = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FLAG,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
        logic flag;
    } t_ctrl_cmd;

    typedef struct packed {
        logic need_flag;
    } t_ctrl_status;

endpackage

### rtl/wrrm_ctrl.sv
module wrrm_ctrl
    import wrrm_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  logic         i_out_ready,
    input  t_ctrl_status i_status,
    output t_ctrl_cmd    o_cmd,
    output logic         o_in_ready,
    output logic         o_out_valid
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = i_status.need_flag ? ST_FLAG : ST_DONE;
            end
            ST_FLAG: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            ST_FLAG: begin
                o_cmd.flag = 1'b1;
            end
            ST_DONE: begin
                o_out_valid = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

### rtl/wrrm_datapath.sv
module wrrm_datapath
    import wrrm_pkg::*;
#(
    parameter int OFFSET_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_ctrl_cmd           i_cmd,
    output t_ctrl_status        o_status,
    input  logic                i_cfg_we,
    input  logic [FIELD_W-1:0]  i_cfg_wdata,
    input  logic [OPCODE_W-1:0] i_opcode,
    input  logic [FIELD_W-1:0]  i_request_length,
    output logic                o_granted,
    output logic [FIELD_W-1:0]  o_grant_offset,
    output logic [FIELD_W-1:0]  o_head_position,
    output logic [FIELD_W-1:0]  o_tail_position,
    output logic                o_nonempty_flag,
    output logic                o_half_full_flag
);

    localparam int AW = ((OFFSET_BITS > FIELD_W) ? OFFSET_BITS : FIELD_W) + 2;

    logic [FIELD_W-1:0]     r_ring;
    t_opcode                r_op;
    logic [FIELD_W-1:0]     r_len;
    logic [OFFSET_BITS-1:0] r_head, n_head;
    logic [OFFSET_BITS-1:0] r_tail, n_tail;
    logic [OFFSET_BITS-1:0] r_end, n_end;
    logic [OFFSET_BITS-1:0] r_pend, n_pend;
    logic                   r_wrapped, n_wrapped;
    logic                   r_holds, n_holds;
    logic                   r_over, n_over;
    logic                   r_granted, n_granted;
    logic [OFFSET_BITS-1:0] r_goff, n_goff;

    logic [AW-1:0]          head_x, tail_x, end_x, len_x, ring_x;
    logic [OFFSET_BITS-1:0] len_w;
    logic [OFFSET_BITS-1:0] tail_sum;
    logic [OFFSET_BITS-1:0] head_base, end_base;
    logic signed [AW:0]     occ;
    logic signed [AW:0]     half;

    assign head_x = AW'(r_head);
    assign tail_x = AW'(r_tail);
    assign end_x  = AW'(r_end);
    assign len_x  = AW'(r_len);
    assign ring_x = AW'(r_ring);
    assign len_w  = OFFSET_BITS'(r_len);

    assign tail_sum  = r_tail + len_w;
    assign head_base = (r_op == OP_COMMIT && !r_holds) ? r_tail : r_head;
    assign end_base  = (r_op == OP_COMMIT && !r_holds) ? r_tail : r_end;

    assign o_status.need_flag = (r_op == OP_COMMIT) || (r_op == OP_RELEASE);

    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_end     = r_end;
        n_pend    = r_pend;
        n_wrapped = r_wrapped;
        n_holds   = r_holds;
        n_granted = 1'b0;
        n_goff    = '0;
        unique case (r_op)
            OP_RESERVE: begin
                n_pend = len_w;
                if (ring_x >= tail_x + len_x) begin
                    if (r_wrapped && (tail_x + len_x > head_x)) begin
                        n_pend = '0;
                    end else begin
                        n_granted = 1'b1;
                        n_goff    = r_tail;
                    end
                end else begin
                    n_tail    = '0;
                    n_wrapped = 1'b1;
                    if (r_holds && (len_x > head_x)) begin
                        n_pend = '0;
                    end else begin
                        n_granted = 1'b1;
                    end
                end
            end
            OP_COMMIT, OP_FAST_COMMIT: begin
                n_head  = head_base;
                n_tail  = tail_sum;
                n_end   = (end_base < tail_sum) ? tail_sum : end_base;
                n_holds = 1'b1;
                n_pend  = '0;
            end
            OP_RELEASE: begin
                if (head_x + len_x >= end_x) begin
                    if (r_pend != '0) begin
                        n_head  = r_tail;
                        n_end   = r_tail;
                        n_holds = 1'b0;
                    end else begin
                        n_head = '0;
                        if (r_tail == r_end) begin
                            n_tail = '0;
                            n_end  = '0;
                            n_holds = 1'b0;
                        end else begin
                            n_end = r_tail;
                            if (r_tail == '0) begin
                                n_holds = 1'b0;
                            end
                        end
                    end
                    n_wrapped = 1'b0;
                end else begin
                    n_head = r_head + len_w;
                end
            end
            default: begin
                n_pend = r_pend;
            end
        endcase
    end

    always_comb begin
        if (tail_x >= head_x) begin
            occ = $signed({1'b0, tail_x}) - $signed({1'b0, head_x});
        end else begin
            occ = $signed({1'b0, end_x}) - $signed({1'b0, head_x}) + $signed({1'b0, tail_x});
        end
        half   = $signed({1'b0, (ring_x >> 1)});
        n_over = occ > half;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring    <= RING_SIZE_RESET;
            r_head    <= '0;
            r_tail    <= '0;
            r_end     <= '0;
            r_pend    <= '0;
            r_wrapped <= 1'b0;
            r_holds   <= 1'b0;
            r_over    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_ring <= i_cfg_wdata;
            end
            if (i_cmd.exec) begin
                r_head    <= n_head;
                r_tail    <= n_tail;
                r_end     <= n_end;
                r_pend    <= n_pend;
                r_wrapped <= n_wrapped;
                r_holds   <= n_holds;
            end
            if (i_cmd.flag) begin
                r_over <= n_over;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= t_opcode'(i_opcode);
            r_len <= i_request_length;
        end
        if (i_cmd.exec) begin
            r_granted <= n_granted;
            r_goff    <= n_goff;
        end
    end

    assign o_granted        = r_granted;
    assign o_grant_offset   = FIELD_W'(r_goff);
    assign o_head_position  = FIELD_W'(r_head);
    assign o_tail_position  = FIELD_W'(r_tail);
    assign o_nonempty_flag  = r_holds;
    assign o_half_full_flag = r_over;

endmodule

### rtl/wrapping_record_ring_manager_top.sv
// Channel   Handshake                      Payload
// in        i_in_valid / o_in_ready        i_opcode, i_request_length
// out       o_out_valid / i_out_ready      o_granted, o_grant_offset, o_head_position,
//                                          o_tail_position, o_nonempty_flag,
//                                          o_half_full_flag
// cfg       i_cfg_we                       i_cfg_wdata (ring size)
//
// Reserve and fast commit pass through EXEC to DONE; commit and release also pass through
// FLAG, the occupancy compare after the pointer update. One item is in flight; the next
// can be accepted the cycle after its result is taken. Synchronous active-low reset clears
// the head and tail positions and the nonempty and half-full flags, and sets ring size to
// 65535; the granted flag and grant offset are not reset.
// A stalled result holds on the output ports until i_out_ready.
module wrapping_record_ring_manager_top
    import wrrm_pkg::*;
#(
    parameter int OFFSET_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [FIELD_W-1:0]  i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [OPCODE_W-1:0] i_opcode,
    input  logic [FIELD_W-1:0]  i_request_length,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_granted,
    output logic [FIELD_W-1:0]  o_grant_offset,
    output logic [FIELD_W-1:0]  o_head_position,
    output logic [FIELD_W-1:0]  o_tail_position,
    output logic                o_nonempty_flag,
    output logic                o_half_full_flag
);

    t_ctrl_cmd    cmd;
    t_ctrl_status status;

    wrrm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid)
    );

    wrrm_datapath #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_opcode         (i_opcode),
        .i_request_length (i_request_length),
        .o_granted        (o_granted),
        .o_grant_offset   (o_grant_offset),
        .o_head_position  (o_head_position),
        .o_tail_position  (o_tail_position),
        .o_nonempty_flag  (o_nonempty_flag),
        .o_half_full_flag (o_half_full_flag)
    );

endmodule

### sim/wrapping_record_ring_manager_top_test.sv
`timescale 1ns / 1ps

module wrapping_record_ring_manager_top_test
    import wrrm_pkg::*;
();

    localparam int HOLD_AT_ITEM = 200;
    localparam int HOLD_CYCLES = 400;
    localparam int ITEMS_PER_PHASE = 115;

    typedef struct {
        t_opcode              op;
        logic [FIELD_W-1:0]   len;
    } t_ring_request;

    typedef struct packed {
        logic               granted;
        logic [FIELD_W-1:0] grant_offset;
        logic [FIELD_W-1:0] head;
        logic [FIELD_W-1:0] tail;
        logic               nonempty;
        logic               half_full;
    } t_ring_status;

    logic                i_clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [FIELD_W-1:0]  cfg_wdata = '0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [OPCODE_W-1:0] opcode = '0;
    logic [FIELD_W-1:0]  request_length = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic                granted;
    logic [FIELD_W-1:0]  grant_offset;
    logic [FIELD_W-1:0]  head_position;
    logic [FIELD_W-1:0]  tail_position;
    logic                nonempty_flag;
    logic                half_full_flag;

    wrapping_record_ring_manager_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_wdata      (cfg_wdata),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_opcode         (opcode),
        .i_request_length (request_length),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_granted        (granted),
        .o_grant_offset   (grant_offset),
        .o_head_position  (head_position),
        .o_tail_position  (tail_position),
        .o_nonempty_flag  (nonempty_flag),
        .o_half_full_flag (half_full_flag)
    );

    // ring bookkeeping as the block should hold it
    logic [FIELD_W-1:0] ring_size_q = RING_SIZE_RESET;
    logic [FIELD_W-1:0] head_q = '0;
    logic [FIELD_W-1:0] tail_q = '0;
    logic [FIELD_W-1:0] data_end_q = '0;
    logic [FIELD_W-1:0] reserved_q = '0;
    logic               wrapped_q = 1'b0;
    logic               holds_data_q = 1'b0;
    logic               over_half_q = 1'b0;

    t_ring_request pending_requests_q[$];
    t_ring_status  status_expected_q[$];

    int  mismatch_count = 0;
    int  accepted_count = 0;
    int  result_count = 0;
    int  grant_count = 0;
    int  ring_sizes_used = 0;
    bit  no_idle = 1'b0;
    int  src_gap = 0;
    int  sink_gap = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    t_opcode            cur_op = OP_RESERVE;
    logic [FIELD_W-1:0] cur_len = '0;

    function automatic t_ring_status ring_step(t_opcode op, logic [FIELD_W-1:0] len);
        t_ring_status r;
        int h;
        int t;
        int e;
        int l;
        int occ;
        r = '0;
        h = head_q;
        t = tail_q;
        e = data_end_q;
        l = len;
        case (op)
            OP_RESERVE: begin
                reserved_q = len;
                if (int'(ring_size_q) - t >= l) begin
                    if (wrapped_q && t + l > h) begin
                        reserved_q = '0;
                    end else begin
                        r.granted = 1'b1;
                        r.grant_offset = tail_q;
                    end
                end else begin
                    tail_q = '0;
                    wrapped_q = 1'b1;
                    if (holds_data_q && l > h) begin
                        reserved_q = '0;
                    end else begin
                        r.granted = 1'b1;
                    end
                end
            end
            OP_COMMIT, OP_FAST_COMMIT: begin
                if (op == OP_COMMIT && !holds_data_q) begin
                    head_q = tail_q;
                    data_end_q = tail_q;
                end
                tail_q = tail_q + len;
                if (data_end_q < tail_q) begin
                    data_end_q = tail_q;
                end
                holds_data_q = 1'b1;
                reserved_q = '0;
            end
            default: begin
                if (h + l >= e) begin
                    if (reserved_q != 0) begin
                        head_q = tail_q;
                        data_end_q = tail_q;
                        holds_data_q = 1'b0;
                    end else begin
                        head_q = '0;
                        if (tail_q == data_end_q) begin
                            tail_q = '0;
                        end
                        data_end_q = tail_q;
                        if (tail_q == 0) begin
                            holds_data_q = 1'b0;
                        end
                    end
                    wrapped_q = 1'b0;
                end else begin
                    head_q = head_q + len;
                end
            end
        endcase
        if (op == OP_COMMIT || op == OP_RELEASE) begin
            h = head_q;
            t = tail_q;
            e = data_end_q;
            occ = (t >= h) ? t - h : e - h + t;
            over_half_q = occ > int'(ring_size_q >> 1);
        end
        r.head = head_q;
        r.tail = tail_q;
        r.nonempty = holds_data_q;
        r.half_full = over_half_q;
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin : drive_proc
        t_ring_request req;
        bit fire;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            fire = in_valid && in_ready;
            if (fire) begin
                status_expected_q.push_back(ring_step(cur_op, cur_len));
                accepted_count++;
            end
            if (in_valid && !fire) begin
                // hold the item until taken
            end else if (src_gap != 0) begin
                src_gap--;
                in_valid <= 1'b0;
            end else if (pending_requests_q.size() != 0) begin
                req = pending_requests_q.pop_front();
                cur_op = req.op;
                cur_len = req.len;
                opcode <= req.op;
                request_length <= req.len;
                in_valid <= 1'b1;
                if (!no_idle && $urandom_range(0, 7) == 0) begin
                    src_gap = $urandom_range(1, 16);
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : sink_proc
        t_ring_status want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                result_count++;
                if (granted) begin
                    grant_count++;
                end
                if (status_expected_q.size() == 0) begin
                    $error("result with no item outstanding");
                    mismatch_count++;
                end else begin
                    want = status_expected_q.pop_front();
                    check_field("granted", want.granted, granted);
                    check_field("grant_offset", want.grant_offset, grant_offset);
                    check_field("head_position", want.head, head_position);
                    check_field("tail_position", want.tail, tail_position);
                    check_field("nonempty_flag", want.nonempty, nonempty_flag);
                    check_field("half_full_flag", want.half_full, half_full_flag);
                end
            end
            if (hold_left != 0) begin
                out_ready <= 1'b0;
            end else if (sink_gap != 0) begin
                sink_gap--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                if (!no_idle && $urandom_range(0, 9) == 0) begin
                    sink_gap = $urandom_range(1, 16);
                end
            end
        end
    end

    // stall the result side once for a long stretch so the input backs up
    always @(posedge i_clk) begin
        if (!rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && accepted_count >= HOLD_AT_ITEM) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    task automatic queue_request(input t_opcode op, input int len);
        t_ring_request req;
        req.op = op;
        req.len = len[FIELD_W-1:0];
        pending_requests_q.push_back(req);
    endtask

    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (pending_requests_q.size() != 0 || status_expected_q.size() != 0 || in_valid);
    endtask

    task automatic write_ring_size(input int value);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value[FIELD_W-1:0];
        @(posedge i_clk);
        cfg_we <= 1'b0;
        ring_size_q = value[FIELD_W-1:0];
        ring_sizes_used++;
        @(negedge i_clk);
    endtask

    task automatic queue_random_phase(input int count, input int ring);
        int n;
        int cap;
        int rlen;
        int sel;
        n = 0;
        while (n < count) begin
            sel = $urandom_range(0, 99);
            cap = ($urandom_range(0, 3) != 0) ? ((ring / 4 > 1) ? ring / 4 : 1) : ring;
            if (sel < 60) begin
                rlen = $urandom_range(0, cap);
                queue_request(OP_RESERVE, rlen);
                queue_request(($urandom_range(0, 4) == 0) ? OP_FAST_COMMIT : OP_COMMIT,
                              $urandom_range(0, rlen));
                n += 2;
            end else if (sel < 85) begin
                queue_request(OP_RELEASE, $urandom_range(0, ring));
                n++;
            end else begin
                queue_request(t_opcode'($urandom_range(0, 3)), $urandom_range(0, 65535));
                n++;
            end
        end
    endtask

    initial begin : main_proc
        int sizes[6];
        sizes = '{1, 64, 1000, 4096, 300, 65535};
        repeat (12) @(posedge i_clk);
        rst_n <= 1'b1;
        write_ring_size(65535);

        queue_request(OP_RESERVE, 0);
        queue_request(OP_RESERVE, 65535);
        queue_request(OP_COMMIT, 65535);
        queue_request(OP_RESERVE, 1);
        queue_request(OP_RELEASE, 0);
        queue_request(OP_RELEASE, 100);
        queue_request(OP_RESERVE, 50);
        queue_request(OP_COMMIT, 50);
        queue_request(OP_RESERVE, 60);
        queue_request(OP_RELEASE, 65535);
        queue_request(OP_RESERVE, 10);
        queue_request(OP_RELEASE, 65535);
        queue_request(OP_COMMIT, 10);
        queue_request(OP_FAST_COMMIT, 65535);
        queue_request(OP_COMMIT, 2);
        queue_request(OP_RELEASE, 1);
        queue_request(OP_RELEASE, 65535);
        queue_request(OP_FAST_COMMIT, 0);
        queue_request(OP_COMMIT, 0);
        queue_request(OP_RELEASE, 65535);
        queue_request(OP_RESERVE, 32768);
        queue_request(OP_COMMIT, 32768);
        queue_request(OP_RELEASE, 1);
        queue_request(OP_RESERVE, 43690);
        queue_request(OP_FAST_COMMIT, 21845);
        wait_drained();

        foreach (sizes[i]) begin
            write_ring_size(sizes[i]);
            if (i == 5) begin
                no_idle = 1'b1;
            end
            queue_random_phase(ITEMS_PER_PHASE, sizes[i]);
            wait_drained();
        end

        repeat (20) @(posedge i_clk);
        if (status_expected_q.size() != 0) begin
            $error("%0d results never arrived", status_expected_q.size());
            mismatch_count++;
        end
        $display("Sent %0d requests under %0d ring sizes; %0d results checked, %0d grants.",
                 accepted_count, ring_sizes_used, result_count, grant_count);
        if (mismatch_count == 0) begin
            $display("wrapping_record_ring_manager_top_test passed");
        end else begin
            $display("wrapping_record_ring_manager_top_test failed");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("Timed out with %0d results outstanding.", status_expected_q.size());
        $display("wrapping_record_ring_manager_top_test failed");
        $finish;
    end

endmodule
